// File: hw/rtl/utc_timestamp_to_epoch_ms_core_macros.svh
// ----------------------------------------------------------------------------
// utc_timestamp_to_epoch_ms_core assertion macros
// Clocked assertion helpers for the checker file.
// ----------------------------------------------------------------------------
`ifndef UTC_TIMESTAMP_TO_EPOCH_MS_CORE_MACROS_SVH
`define UTC_TIMESTAMP_TO_EPOCH_MS_CORE_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define UTC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// antecedent this cycle, consequent on the next
`define UTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `UTC_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// File: hw/rtl/utc_ts2ms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_ts2ms_pkg
// Shared types, constants and tables of the timestamp to epoch-ms core.
// ----------------------------------------------------------------------------
package utc_ts2ms_pkg;

    localparam int W_CHAR = 8;
    localparam int W_MS   = 50;
    localparam int W_DATA = 56;
    localparam int W_YEAR = 15;
    localparam int W_FLD  = 8;
    localparam int W_FRAC = 10;

    localparam int C_YEAR_BIAS = 1200;      // three 400-year eras
    localparam int C_DAYS_BIAS = 1157759;   // 719468 + 3 * 146097
    localparam int C_RECIP25   = 2622;      // ceil(2^16 / 25)

    typedef struct packed {
        logic [W_YEAR-1:0] year;
        logic [W_FLD-1:0]  mon;
        logic [W_FLD-1:0]  day;
        logic [W_FLD-1:0]  hour;
        logic [W_FLD-1:0]  minute;
        logic [W_FLD-1:0]  sec;
        logic [W_FRAC-1:0] frac;
        logic              ok;
    } t_fields;

    typedef struct packed {
        logic feed;
        logic last;
        logic clr;
    } t_psr_cmd;

    typedef struct packed {
        logic yr;
        logic mul;
        logic days;
        logic mins;
        logic load;
    } t_cnv_cmd;

    // days from March 1st to the first of month m (March-based year)
    function automatic logic [8:0] month_offset(input logic [W_FLD-1:0] m);
        logic [8:0] r;
        case (m)
            8'd3:    r = 9'd0;
            8'd4:    r = 9'd31;
            8'd5:    r = 9'd61;
            8'd6:    r = 9'd92;
            8'd7:    r = 9'd122;
            8'd8:    r = 9'd153;
            8'd9:    r = 9'd184;
            8'd10:   r = 9'd214;
            8'd11:   r = 9'd245;
            8'd12:   r = 9'd275;
            8'd1:    r = 9'd306;
            8'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/utc_ts2ms_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_ts2ms_parser
// Character scanner: splits the text into year..second and fraction fields.
// ----------------------------------------------------------------------------
module utc_ts2ms_parser (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire utc_ts2ms_pkg::t_psr_cmd            i_cmd,
    input  wire logic [utc_ts2ms_pkg::W_CHAR-1:0]   i_char,
    input  wire logic                               i_has,
    output utc_ts2ms_pkg::t_fields                  o_fields
);

    localparam logic [3:0] PH_YEAR = 4'd0;
    localparam logic [3:0] PH_MON  = 4'd2;
    localparam logic [3:0] PH_DAY  = 4'd4;
    localparam logic [3:0] PH_T    = 4'd5;
    localparam logic [3:0] PH_HOUR = 4'd6;
    localparam logic [3:0] PH_COL1 = 4'd7;
    localparam logic [3:0] PH_MIN  = 4'd8;
    localparam logic [3:0] PH_SEC  = 4'd10;
    localparam logic [3:0] PH_DOT  = 4'd11;
    localparam logic [3:0] PH_FRAC = 4'd12;
    localparam logic [3:0] PH_DONE = 4'd13;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_T     = 8'd84;

    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_wused, n_wused;
    logic        r_neg, n_neg;
    logic [2:0]  r_dcnt, n_dcnt;
    logic [14:0] r_year, n_year;
    logic [7:0]  r_mon, n_mon;
    logic [7:0]  r_day, n_day;
    logic [7:0]  r_hour, n_hour;
    logic [7:0]  r_min, n_min;
    logic [7:0]  r_sec, n_sec;
    logic [9:0]  r_frac, n_frac;
    logic        r_fail, n_fail;
    logic        r_ok, n_ok;

    logic        is_dig, is_ws, is_sign, fld_ph;
    logic        accum, commit, do_sep;
    logic [3:0]  dg, sep_ph;
    logic [2:0]  maxw;
    logic [7:0]  want;
    logic [14:0] fld_cur, fld_new;

    assign is_dig  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_ws   = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign is_sign = (i_char == CH_PLUS) || (i_char == CH_MINUS);
    assign dg      = i_char[3:0];
    assign fld_ph  = (r_phase <= PH_SEC) && !r_phase[0];
    assign maxw    = (r_phase == PH_YEAR) ? 3'd4 : 3'd2;

    always_comb begin
        case (r_phase)
            PH_YEAR: fld_cur = r_year;
            PH_MON:  fld_cur = 15'($signed(r_mon));
            PH_DAY:  fld_cur = 15'($signed(r_day));
            PH_HOUR: fld_cur = 15'($signed(r_hour));
            PH_MIN:  fld_cur = 15'($signed(r_min));
            default: fld_cur = 15'($signed(r_sec));
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_wused = r_wused;
        n_neg   = r_neg;
        n_dcnt  = r_dcnt;
        n_year  = r_year;
        n_mon   = r_mon;
        n_day   = r_day;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_frac  = r_frac;
        n_fail  = r_fail;
        n_ok    = r_ok;
        accum   = 1'b0;
        commit  = 1'b0;
        do_sep  = 1'b0;
        fld_new = fld_cur;
        sep_ph  = r_phase;
        want    = CH_MINUS;
        if (i_cmd.clr) begin
            n_phase = PH_YEAR;
            n_wused = 3'd0;
            n_neg   = 1'b0;
            n_dcnt  = 3'd0;
            n_year  = '0;
            n_mon   = '0;
            n_day   = '0;
            n_hour  = '0;
            n_min   = '0;
            n_sec   = '0;
            n_frac  = '0;
            n_fail  = 1'b0;
            n_ok    = 1'b0;
        end else if (i_cmd.feed) begin
            if (i_has && !r_fail) begin
                if (fld_ph) begin
                    if (r_wused == 3'd0 && is_ws) begin
                        n_wused = r_wused;
                    end else if (r_wused == 3'd0 && is_sign) begin
                        n_neg   = (i_char == CH_MINUS);
                        n_wused = 3'd1;
                    end else if (is_dig) begin
                        accum   = 1'b1;
                        n_wused = r_wused + 3'd1;
                        n_dcnt  = r_dcnt + 3'd1;
                        commit  = (n_wused >= maxw);
                    end else if (r_dcnt == 3'd0) begin
                        n_fail = 1'b1;
                    end else begin
                        commit = 1'b1;
                        do_sep = 1'b1;
                    end
                end else begin
                    do_sep = 1'b1;
                end
            end

            if (accum) begin
                fld_new = 15'(fld_cur * 15'd10 + 15'(dg));
            end
            if (commit && r_neg) begin
                fld_new = 15'd0 - fld_new;
            end
            if (accum || commit) begin
                case (r_phase)
                    PH_YEAR: n_year = fld_new;
                    PH_MON:  n_mon  = fld_new[7:0];
                    PH_DAY:  n_day  = fld_new[7:0];
                    PH_HOUR: n_hour = fld_new[7:0];
                    PH_MIN:  n_min  = fld_new[7:0];
                    default: n_sec  = fld_new[7:0];
                endcase
            end
            if (commit) begin
                n_phase = r_phase + 4'd1;
                n_wused = 3'd0;
                n_neg   = 1'b0;
                n_dcnt  = 3'd0;
                sep_ph  = r_phase + 4'd1;
            end

            if (sep_ph == PH_T) begin
                want = CH_T;
            end else if (sep_ph >= PH_COL1) begin
                want = CH_COLON;
            end
            if (do_sep) begin
                if (sep_ph < PH_SEC) begin
                    if (i_char == want) begin
                        n_phase = sep_ph + 4'd1;
                    end else begin
                        n_fail = 1'b1;
                    end
                end else if (sep_ph == PH_DOT) begin
                    if (i_char == CH_DOT) begin
                        n_phase = PH_FRAC;
                        n_wused = 3'd0;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end else if (sep_ph == PH_FRAC) begin
                    n_frac  = 10'(r_frac * 10'd10 + (is_dig ? 10'(dg) : 10'd0));
                    n_wused = r_wused + 3'd1;
                    if (n_wused >= 3'd3) begin
                        n_phase = PH_DONE;
                    end
                end
            end

            // end of text: close a pending seconds field, pad the fraction, set the ok flag
            if (i_cmd.last) begin
                if (!n_fail && n_phase == PH_SEC && n_dcnt != 3'd0) begin
                    n_sec   = n_neg ? (8'd0 - n_sec) : n_sec;
                    n_phase = PH_DOT;
                end
                if (!n_fail && n_phase == PH_FRAC) begin
                    case (n_wused)
                        3'd0:    n_frac = 10'd0;
                        3'd1:    n_frac = 10'(n_frac * 10'd100);
                        3'd2:    n_frac = 10'(n_frac * 10'd10);
                        default: n_frac = n_frac;
                    endcase
                end
                n_ok = !n_fail && (n_phase >= PH_DOT)
                    && ($signed(n_mon) >= 8'sd1) && ($signed(n_mon) <= 8'sd12)
                    && ($signed(n_day) >= 8'sd1) && ($signed(n_day) <= 8'sd31);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_YEAR;
            r_wused <= 3'd0;
            r_neg   <= 1'b0;
            r_dcnt  <= 3'd0;
            r_year  <= '0;
            r_mon   <= '0;
            r_day   <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_frac  <= '0;
            r_fail  <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_wused <= n_wused;
            r_neg   <= n_neg;
            r_dcnt  <= n_dcnt;
            r_year  <= n_year;
            r_mon   <= n_mon;
            r_day   <= n_day;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_frac  <= n_frac;
            r_fail  <= n_fail;
            r_ok    <= n_ok;
        end
    end

    assign o_fields.year   = r_year;
    assign o_fields.mon    = r_mon;
    assign o_fields.day    = r_day;
    assign o_fields.hour   = r_hour;
    assign o_fields.minute = r_min;
    assign o_fields.sec    = r_sec;
    assign o_fields.frac   = r_frac;
    assign o_fields.ok     = r_ok;

endmodule
`default_nettype wire

// File: hw/rtl/utc_ts2ms_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_ts2ms_conv
// Datapath: civil date and time fields to epoch milliseconds, one step a cycle while commanded.
// ----------------------------------------------------------------------------
module utc_ts2ms_conv (
    input  wire logic                             i_clk,
    input  wire utc_ts2ms_pkg::t_cnv_cmd          i_cmd,
    input  wire utc_ts2ms_pkg::t_fields           i_fields,
    output logic [utc_ts2ms_pkg::W_MS-1:0]        o_ms,
    output logic                                  o_ok
);

    logic [13:0]        r_yp;
    logic [23:0]        r_q25p;
    logic [22:0]        r_y365;
    logic [9:0]         r_doy;
    logic signed [22:0] r_days;
    logic signed [33:0] r_mins;
    logic [49:0]        r_ms;
    logic               r_ok;

    logic        mon_le2;
    logic [13:0] n_yp;
    logic [9:0]  n_doy;
    logic [6:0]  cent;
    logic [22:0] n_days;
    logic [33:0] n_mins;
    logic [49:0] n_ms;

    // year shifted to March-based and biased positive by whole eras
    assign mon_le2 = ($signed(i_fields.mon) <= 8'sd2);
    assign n_yp    = 14'($signed(i_fields.year)) - 14'(mon_le2)
                   + 14'(utc_ts2ms_pkg::C_YEAR_BIAS);
    assign n_doy   = 10'(utc_ts2ms_pkg::month_offset(i_fields.mon))
                   + 10'($signed(i_fields.day)) - 10'd1;

    // (yp/4)/25 = yp/100, then /4 again = yp/400
    assign cent   = r_q25p[22:16];
    assign n_days = r_y365 + 23'(r_yp[13:2]) - 23'(cent) + 23'(cent[6:2])
                  + 23'($signed(r_doy)) - 23'(utc_ts2ms_pkg::C_DAYS_BIAS);
    assign n_mins = 34'(r_days * 34'sd1440)
                  + 34'($signed(i_fields.hour)) * 34'd60
                  + 34'($signed(i_fields.minute));
    assign n_ms   = $signed(50'(r_mins)) * 50'sd60000
                  + 50'($signed(i_fields.sec)) * 50'd1000
                  + 50'(i_fields.frac);

    always_ff @(posedge i_clk) begin
        if (i_cmd.yr) begin
            r_yp  <= n_yp;
            r_doy <= n_doy;
        end
        if (i_cmd.mul) begin
            r_q25p <= 24'(r_yp[13:2]) * 24'(utc_ts2ms_pkg::C_RECIP25);
            r_y365 <= 23'(r_yp) * 23'd365;
        end
        if (i_cmd.days) begin
            r_days <= $signed(n_days);
        end
        if (i_cmd.mins) begin
            r_mins <= $signed(n_mins);
        end
        if (i_cmd.load) begin
            r_ms <= i_fields.ok ? n_ms : '0;
            r_ok <= i_fields.ok;
        end
    end

    assign o_ms = r_ms;
    assign o_ok = r_ok;

endmodule
`default_nettype wire

// File: hw/rtl/utc_ts2ms_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_ts2ms_ctrl
// Controller: input handshake, conversion sequence and output valid.
// ----------------------------------------------------------------------------
module utc_ts2ms_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    input  wire logic                     i_s_tlast,
    output logic                          o_s_tready,
    input  wire logic                     i_m_tready,
    output logic                          o_m_tvalid,
    output utc_ts2ms_pkg::t_psr_cmd       o_psr_cmd,
    output utc_ts2ms_pkg::t_cnv_cmd       o_cnv_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MUL,
        ST_DAYS,
        ST_MINS,
        ST_LOAD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   s_acc, load;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign load       = (r_state == ST_LOAD) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (s_acc && i_s_tlast) begin
                    n_state = ST_YEAR;
                end
            end
            ST_YEAR: n_state = ST_MUL;
            ST_MUL:  n_state = ST_DAYS;
            ST_DAYS: n_state = ST_MINS;
            ST_MINS: n_state = ST_LOAD;
            ST_LOAD: begin
                if (load) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_psr_cmd.feed = s_acc;
    assign o_psr_cmd.last = s_acc && i_s_tlast;
    assign o_psr_cmd.clr  = load;
    assign o_cnv_cmd.yr   = (r_state == ST_YEAR);
    assign o_cnv_cmd.mul  = (r_state == ST_MUL);
    assign o_cnv_cmd.days = (r_state == ST_DAYS);
    assign o_cnv_cmd.mins = (r_state == ST_MINS);
    assign o_cnv_cmd.load = load;

endmodule
`default_nettype wire

// File: hw/rtl/utc_timestamp_to_epoch_ms_core.sv
// ----------------------------------------------------------------------------
// utc_timestamp_to_epoch_ms_core: ISO 8601 UTC text to Unix epoch milliseconds
// One character per cycle while idle; the request with tlast starts the conversion:
// year, multiply, days, minutes, load; no character is taken until the result is loaded.
// A result not yet taken holds the conversion in its final step.
// Synchronous active-low reset clears the scanner and drops the result valid.
// ----------------------------------------------------------------------------
`default_nettype none
module utc_timestamp_to_epoch_ms_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tuser,   // [0] has_char
    input  wire logic        s_axis_tlast,   // last_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [49:0] epoch_ms, [55:50] zero
    output logic             m_axis_tuser    // [0] parsed_ok
);

    utc_ts2ms_pkg::t_psr_cmd psr_cmd;
    utc_ts2ms_pkg::t_cnv_cmd cnv_cmd;
    utc_ts2ms_pkg::t_fields  fields;
    logic [utc_ts2ms_pkg::W_MS-1:0] ms;

    utc_ts2ms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_psr_cmd  (psr_cmd),
        .o_cnv_cmd  (cnv_cmd)
    );

    utc_ts2ms_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (psr_cmd),
        .i_char   (s_axis_tdata),
        .i_has    (s_axis_tuser),
        .o_fields (fields)
    );

    utc_ts2ms_conv u_conv (
        .i_clk    (i_clk),
        .i_cmd    (cnv_cmd),
        .i_fields (fields),
        .o_ms     (ms),
        .o_ok     (m_axis_tuser)
    );

    assign m_axis_tdata = {(utc_ts2ms_pkg::W_DATA - utc_ts2ms_pkg::W_MS)'(0), ms};

endmodule
`default_nettype wire

// File: hw/rtl/utc_ts2ms_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utc_ts2ms_checker
// Port-level checks of the core, bound to the top level.
// ----------------------------------------------------------------------------
`include "utc_timestamp_to_epoch_ms_core_macros.svh"

module utc_ts2ms_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        i_s_tready,
    input wire logic        i_s_tlast,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [55:0] i_m_tdata,
    input wire logic        i_m_tuser
);

    `UTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "result changed while stalled")

    `UTC_ASSERT(a_reject_zero, i_clk, i_rst_n, (i_m_tvalid && !i_m_tuser) |-> (i_m_tdata == 56'd0), "rejected text gave nonzero epoch")

    `UTC_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, i_s_tvalid && i_s_tready && i_s_tlast, !i_s_tready, "request taken during conversion")

    `UTC_ASSERT(a_launch_busy, i_clk, i_rst_n, $rose(i_m_tvalid) |-> !$past(i_s_tready), "result launched outside conversion")

endmodule

bind utc_timestamp_to_epoch_ms_core utc_ts2ms_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tlast  (s_axis_tlast),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
`default_nettype wire

// File: test/tb_utc_timestamp_to_epoch_ms_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utc_timestamp_to_epoch_ms_core
// Streams timestamp texts into the core one byte per request: a few fixed
// texts at the extremes, then random well-formed and broken texts, with idle
// requests, sender bursts and receiver stalls. A scoreboard scans each
// accepted byte, computes the epoch milliseconds of every finished text and
// compares each returned result in order.
// ----------------------------------------------------------------------------
module tb_utc_timestamp_to_epoch_ms_core;

    localparam int W_MS   = utc_ts2ms_pkg::W_MS;
    localparam int W_DATA = utc_ts2ms_pkg::W_DATA;

    // scanner phases from the seconds field on
    localparam int PH_SEC  = 10;
    localparam int PH_DOT  = 11;
    localparam int PH_FRAC = 12;
    localparam int PH_DONE = 13;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam int N_CHARS    = 800;
    localparam int HOLD_LEN   = 300;
    localparam int TAIL_WAIT  = 12;

    typedef struct {
        logic [W_MS-1:0] ms;
        logic            ok;
    } t_stamp_result;

    class epoch_ms_scoreboard;
        t_stamp_result expected_stamps[$];
        int errors;
        int phase;
        int wused;
        int ndigits;
        int frac;
        bit neg;
        bit failed;
        int fld[6];   // year, month, day, hour, minute, second

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase = 0;
            wused = 0;
            ndigits = 0;
            frac = 0;
            neg = 0;
            failed = 0;
            foreach (fld[i]) fld[i] = 0;
        endfunction

        function int pending();
            return expected_stamps.size();
        endfunction

        function void close_field();
            if (neg) fld[phase / 2] = -fld[phase / 2];
            phase++;
            wused = 0;
            neg = 0;
            ndigits = 0;
        endfunction

        function void scan_char(logic [7:0] c);
            bit again;
            bit digit;
            int maxw;
            logic [7:0] want;
            digit = (c >= "0" && c <= "9");
            again = 1;
            while (again && !failed) begin
                again = 0;
                if (phase <= PH_SEC && phase % 2 == 0) begin
                    maxw = (phase == 0) ? 4 : 2;
                    if (wused == 0 && (c == " " || (c >= CH_TAB && c <= CH_CR))) begin
                        // leading whitespace, not counted
                    end else if (wused == 0 && (c == "+" || c == "-")) begin
                        neg = (c == "-");
                        wused = 1;
                    end else if (digit) begin
                        fld[phase / 2] = fld[phase / 2] * 10 + int'(c - "0");
                        wused++;
                        ndigits++;
                        if (wused >= maxw) close_field();
                    end else if (ndigits == 0) begin
                        failed = 1;
                    end else begin
                        // field ends early, byte goes to the separator
                        close_field();
                        again = 1;
                    end
                end else if (phase < PH_SEC) begin
                    want = (phase == 5) ? "T" : (phase >= 7) ? ":" : "-";
                    if (c == want) phase++;
                    else failed = 1;
                end else if (phase == PH_DOT) begin
                    if (c == ".") begin
                        phase = PH_FRAC;
                        wused = 0;
                    end else begin
                        phase = PH_DONE;
                    end
                end else if (phase == PH_FRAC) begin
                    frac = frac * 10 + (digit ? int'(c - "0") : 0);
                    wused++;
                    if (wused >= 3) phase = PH_DONE;
                end
            end
        endfunction

        function longint civil_days(longint y, longint m, longint d);
            longint era;
            longint yoe;
            longint doy;
            longint doe;
            if (m <= 2) y -= 1;
            era = (y >= 0 ? y : y - 399) / 400;
            yoe = y - era * 400;
            doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468;
        endfunction

        function void note_request(logic [7:0] c, logic has, logic last);
            t_stamp_result r;
            longint ms;
            if (has) scan_char(c);
            if (!last) return;
            if (!failed && phase == PH_SEC && ndigits > 0) close_field();
            if (!failed && phase == PH_FRAC) begin
                while (wused < 3) begin
                    frac *= 10;
                    wused++;
                end
            end
            r.ok = !failed && phase >= PH_DOT && fld[1] >= 1 && fld[1] <= 12
                   && fld[2] >= 1 && fld[2] <= 31;
            ms = 0;
            if (r.ok)
                ms = ((civil_days(fld[0], fld[1], fld[2]) * 24 + fld[3]) * 60 + fld[4])
                     * 60000 + longint'(fld[5]) * 1000 + frac;
            r.ms = ms[W_MS-1:0];
            expected_stamps = {expected_stamps, r};
            restart();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [W_DATA-1:0] data, logic ok);
            t_stamp_result e;
            if (expected_stamps.size() == 0) begin
                report($sformatf("result with none pending, epoch_ms=%0d ok=%0b",
                                 $signed(data[W_MS-1:0]), ok));
                return;
            end
            e = expected_stamps.pop_front();
            if (data[W_MS-1:0] !== e.ms)
                report($sformatf("epoch_ms got %0d exp %0d",
                                 $signed(data[W_MS-1:0]), $signed(e.ms)));
            if (data[W_DATA-1:W_MS] !== '0)
                report($sformatf("tdata pad bits got %0h", data[W_DATA-1:W_MS]));
            if (ok !== e.ok)
                report($sformatf("parsed_ok got %0b exp %0b", ok, e.ok));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;    // [7:0] char_code
    logic              s_axis_tuser = 1'b0;  // [0] has_char
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [W_DATA-1:0] m_axis_tdata;         // [49:0] epoch_ms, [55:50] zero
    logic              m_axis_tuser;         // [0] parsed_ok

    epoch_ms_scoreboard sb = new();

    int  burst_left = 0;
    int  chars_sent = 0;
    bit  hold_start = 0;
    int  hold_cycles = 0;
    int  rx_mode = 0;
    int  rx_left = 0;
    int  rx_tick = 0;

    utc_timestamp_to_epoch_ms_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // receiver: changing stall patterns, plus one long hold-off on demand
    always @(posedge i_clk) begin
        rx_tick++;
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles--;
        end else if (hold_start) begin
            hold_start = 0;
            hold_cycles = HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(10, 80);
            end
            rx_left--;
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= $urandom_range(0, 1);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (rx_tick % 5 != 0);
            endcase
        end
    end

    task automatic send_req(input logic [7:0] c, input logic has, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= has;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // a text ends on its last byte, or on a separate marker without a byte
    task automatic send_text(input byte unsigned t[$]);
        bit tail_mark;
        tail_mark = (t.size() == 0) || ($urandom_range(0, 5) == 0);
        foreach (t[i]) begin
            if ($urandom_range(0, 15) == 0)
                send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_req(t[i], 1'b1, !tail_mark && i == t.size() - 1);
            chars_sent++;
        end
        if (tail_mark) begin
            send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            chars_sent++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic void add_byte(ref byte unsigned t[$], input int v);
        byte unsigned b;
        b = 8'(v);
        t = {t, b};
    endfunction

    function automatic void put_digits(ref byte unsigned t[$], input int v, input int n);
        int p;
        p = 1;
        repeat (n - 1) p *= 10;
        repeat (n) begin
            add_byte(t, "0" + (v / p) % 10);
            p /= 10;
        end
    endfunction

    function automatic void put_field(ref byte unsigned t[$], input int w,
                                      input int lo, input int hi);
        int v;
        int style;
        int k;
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, (w == 4) ? 9999 : 99)
                                        : $urandom_range(lo, hi);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                k = $urandom_range(0, 5);
                add_byte(t, (k == 5) ? " " : CH_TAB + k);
            end
        end
        style = $urandom_range(0, 49);
        if (style <= 2) begin
            add_byte(t, $urandom_range(0, 1) ? "-" : "+");
            put_digits(t, v, w - 1);
        end else if (style <= 5) begin
            put_digits(t, v, $urandom_range(1, w - 1));
        end else if (style == 6) begin
            add_byte(t, $urandom_range(0, 1) ? "-" : "+");
        end else begin
            put_digits(t, v, w);
        end
    endfunction

    function automatic void put_sep(ref byte unsigned t[$], input logic [7:0] c);
        add_byte(t, ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : c);
    endfunction

    function automatic void make_text(ref byte unsigned t[$]);
        int kind;
        int keep;
        kind = $urandom_range(0, 15);
        t.delete();
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) add_byte(t, $urandom_range(0, 255));
            return;
        end
        put_field(t, 4, 1900, 2100);
        put_sep(t, "-");
        put_field(t, 2, 1, 12);
        put_sep(t, "-");
        put_field(t, 2, 1, 31);
        put_sep(t, "T");
        put_field(t, 2, 0, 23);
        put_sep(t, ":");
        put_field(t, 2, 0, 59);
        put_sep(t, ":");
        put_field(t, 2, 0, 59);
        case ($urandom_range(0, 5))
            1: begin
                add_byte(t, ".");
                put_digits(t, $urandom_range(0, 999), 3);
            end
            2: begin
                add_byte(t, ".");
                repeat ($urandom_range(0, 2)) add_byte(t, "0" + $urandom_range(0, 9));
            end
            3: begin
                add_byte(t, ".");
                repeat (3) add_byte(t, $urandom_range(0, 255));
            end
            4: add_byte(t, "Z");
            5: begin
                add_byte(t, ".");
                put_digits(t, $urandom_range(0, 999), 3);
                repeat ($urandom_range(1, 3)) add_byte(t, $urandom_range(0, 255));
            end
            default: ;
        endcase
        if (kind == 1) begin
            keep = $urandom_range(0, t.size() - 1);
            while (t.size() > keep) void'(t.pop_back());
        end
    endfunction

    initial begin
        byte unsigned text[$];
        string full_stamp;
        int n_texts;
        full_stamp = "9999-12-31T99:99:99.999";
        n_texts = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        text = {};
        send_text(text);
        text = {8'h00};
        send_text(text);
        text = {8'hFF};
        send_text(text);
        text = {};
        for (int i = 0; i < full_stamp.len(); i++) add_byte(text, full_stamp[i]);
        send_text(text);
        drain();

        while (chars_sent < N_CHARS) begin
            make_text(text);
            send_text(text);
            n_texts++;
            if (n_texts == 12) hold_start = 1;
            if (n_texts == 25) drain();
        end

        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: utc_timestamp_to_epoch_ms_core.f
+incdir+hw/rtl
hw/rtl/utc_ts2ms_pkg.sv
hw/rtl/utc_ts2ms_parser.sv
hw/rtl/utc_ts2ms_conv.sv
hw/rtl/utc_ts2ms_ctrl.sv
hw/rtl/utc_timestamp_to_epoch_ms_core.sv
hw/rtl/utc_ts2ms_checker.sv
test/tb_utc_timestamp_to_epoch_ms_core.sv
